@@ hw/rtl/crc4b_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc4b_pkg
// Shared constants, types and functions of the CRC-16 / 4b6b frame encoder.
// ----------------------------------------------------------------------------
package crc4b_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned CODE12_W   = 12;
  localparam int unsigned MAX_BYTES  = 6;
  localparam int unsigned WORD_W     = MAX_BYTES * BYTE_W;
  localparam int unsigned CNT_W      = $clog2(MAX_BYTES + 1);

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // byte counts of one encoded item
  localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
  localparam logic [CNT_W-1:0] CNT_PAIR = 3'd3;
  localparam logic [CNT_W-1:0] CNT_ODD  = 3'd5;
  localparam logic [CNT_W-1:0] CNT_FULL = 3'd6;

  typedef struct packed {
    logic [WORD_W-1:0] word;       // coded bytes, first byte in the top bits
    logic [CNT_W-1:0]  count;      // number of valid bytes in word
    logic              frame_end;  // last byte of word closes the frame
  } enc_res_t;

  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [5:0] nib_code(input logic [3:0] n);
    logic [5:0] c;
    case (n)
      4'h0:    c = 6'h15;
      4'h1:    c = 6'h31;
      4'h2:    c = 6'h32;
      4'h3:    c = 6'h23;
      4'h4:    c = 6'h34;
      4'h5:    c = 6'h25;
      4'h6:    c = 6'h26;
      4'h7:    c = 6'h16;
      4'h8:    c = 6'h1A;
      4'h9:    c = 6'h19;
      4'hA:    c = 6'h2A;
      4'hB:    c = 6'h0B;
      4'hC:    c = 6'h2C;
      4'hD:    c = 6'h0D;
      4'hE:    c = 6'h0E;
      4'hF:    c = 6'h1C;
      default: c = 6'h15;
    endcase
    return c;
  endfunction

  function automatic logic [CODE12_W-1:0] code12(input logic [BYTE_W-1:0] b);
    return {nib_code(b[7:4]), nib_code(b[3:0])};
  endfunction

endpackage

@@ hw/rtl/crc4b_enc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc4b_enc
// Combinational CRC update and 4b6b mapping of one registered payload byte.
// ----------------------------------------------------------------------------
module crc4b_enc
  import crc4b_pkg::*;
(
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic [CRC_W-1:0]  crc,
  input  logic [BYTE_W-1:0] held_byte,
  input  logic              held_valid,
  output logic [CRC_W-1:0]  crc_upd,
  output enc_res_t          res
);

  logic [CODE12_W-1:0] c_held;
  logic [CODE12_W-1:0] c_byte;
  logic [CODE12_W-1:0] c_crc_hi;
  logic [CODE12_W-1:0] c_crc_lo;

  assign crc_upd  = crc_update(crc, in_byte);
  assign c_held   = code12(held_byte);
  assign c_byte   = code12(in_byte);
  assign c_crc_hi = code12(crc_upd[15:8]);
  assign c_crc_lo = code12(crc_upd[7:0]);

  always_comb begin
    res.frame_end = in_last;
    res.word      = '0;
    res.count     = CNT_NONE;
    if (in_last) begin
      if (held_valid) begin
        res.word  = {c_held, c_byte, c_crc_hi, c_crc_lo};
        res.count = CNT_FULL;
      end else begin
        // odd byte count: the lone crc low byte is padded with a zero nibble
        res.word  = {c_byte, c_crc_hi, c_crc_lo, 4'h0, 8'h00};
        res.count = CNT_ODD;
      end
    end else if (held_valid) begin
      res.word  = {c_held, c_byte, 24'h000000};
      res.count = CNT_PAIR;
    end
  end

endmodule

@@ hw/rtl/crc4b_ser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc4b_ser
// Result buffer that shifts the coded bytes of one item out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module crc4b_ser
  import crc4b_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  enc_res_t          res,
  output logic              load_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,
  output logic              m_tlast
);

  logic [WORD_W-1:0] data;
  logic [CNT_W-1:0]  cnt;
  logic              fend;

  // a new word may enter while the final buffered byte leaves
  assign load_ready = (cnt == CNT_NONE) ||
                      ((cnt == CNT_W'(1)) && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= CNT_NONE;
      fend <= 1'b0;
    end else if (load) begin
      data <= res.word;
      cnt  <= res.count;
      fend <= res.frame_end;
    end else if ((cnt != CNT_NONE) && m_tready) begin
      data <= {data[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign m_tvalid = (cnt != CNT_NONE);
  assign m_tdata  = data[WORD_W-1 -: BYTE_W];
  assign m_tlast  = fend && (cnt == CNT_W'(1));

endmodule

@@ hw/rtl/crc16_4b6b_frame_encoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_4b6b_frame_encoder_unit
// CRC-16/CCITT-FALSE framing with a 4b6b line code, byte stream in and out.
// ----------------------------------------------------------------------------
// Payload bytes enter on the slave stream (s_tdata, s_tlast marks the final
// payload byte of a frame). The CRC runs over the payload and is appended
// high byte first; every byte maps to twelve code bits, packed MSB first and
// sent out one byte per transfer on the master stream, m_tlast on the final
// coded byte of the frame. An odd total byte count ends with a byte padded
// with four zero bits.
// Path: the first coded byte of an item is taken from the output byte buffer,
// loaded from the input register that holds its input transfer. Two payload
// bytes give three coded bytes and the frame end adds the coded CRC, so the
// one-byte output port, not the input, limits how fast a frame goes out.
// An input register and the output byte buffer are separate stages: a new
// byte is taken while coded bytes still wait. When the receiver stalls the
// buffer holds, the input register fills and s_tready drops.
// Reset clears both stages, sets the CRC to 0xFFFF and drops any held byte.
// ----------------------------------------------------------------------------
module crc16_4b6b_frame_encoder_unit
  import crc4b_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,   // [7:0] code_byte
  output logic              m_tlast
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  logic [CRC_W-1:0]  crc;
  logic [BYTE_W-1:0] held_byte;
  logic              held_valid;

  logic [CRC_W-1:0]  crc_upd;
  enc_res_t          enc_res;
  logic              ser_ready;
  logic              ser_load;
  logic              adv;

  crc4b_enc u_enc (
    .in_byte    (in_byte),
    .in_last    (in_last),
    .crc        (crc),
    .held_byte  (held_byte),
    .held_valid (held_valid),
    .crc_upd    (crc_upd),
    .res        (enc_res)
  );

  // an item that only gets held needs no room in the output buffer
  assign adv      = in_valid && ((enc_res.count == CNT_NONE) || ser_ready);
  assign ser_load = adv && (enc_res.count != CNT_NONE);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
      in_byte  <= s_tdata;
      in_last  <= s_tlast;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= CRC_INIT;
      held_valid <= 1'b0;
      held_byte  <= '0;
    end else if (adv) begin
      if (in_last) begin
        crc        <= CRC_INIT;
        held_valid <= 1'b0;
        held_byte  <= '0;
      end else begin
        crc        <= crc_upd;
        held_valid <= !held_valid;
        held_byte  <= in_byte;
      end
    end
  end

  crc4b_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (ser_load),
    .res        (enc_res),
    .load_ready (ser_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // frame end leaves the crc and pairing state ready for the next frame
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (adv && in_last) |=> (crc == CRC_INIT) && !held_valid)
    else $error("crc or held byte not cleared after frame end");

  // a blocked item stays put in the input register
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !adv) |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("input register changed while blocked");

  // only the first byte of a pair within a frame produces no coded bytes
  a_silent_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && (enc_res.count == CNT_NONE)) |-> !in_last && !held_valid)
    else $error("item dropped without coded output");

endmodule
